[rtl/core/mlqs_pkg.sv]
// Shared types, constants and helper functions of the multilevel queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlqs_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int IO_TICKS_DEF    = 3;

	localparam int TICK_W     = 16;
	localparam int PID_W      = 8;
	localparam int NUM_W      = 9;
	localparam int BURST_W    = 4;
	localparam int LVL_W      = 2;
	localparam int IOL_W      = 2;
	localparam int INT_W      = 4;
	localparam int THR_W      = 8;
	localparam int PROMO_W    = 6;
	localparam int RET_W      = 5;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Priority levels
	localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LVL_W-1:0] LVL_HIGH = 2'd1;
	localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
	localparam logic [LVL_W-1:0] LVL_LOW  = 2'd3;

	// Admission outcomes
	localparam logic [STAT_W-1:0] ADM_NONE   = 2'd0;
	localparam logic [STAT_W-1:0] ADM_OK     = 2'd1;
	localparam logic [STAT_W-1:0] ADM_NO_MEM = 2'd2;
	localparam logic [STAT_W-1:0] ADM_FULL   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SJF     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 2'd3;

	// One process table entry; was_running doubles as the "exempt from aging" mark
	typedef struct packed {
		logic [PID_W-1:0]   pid;
		logic [TICK_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] remaining;
		logic [LVL_W-1:0]   level;
		logic               io_cap;
		logic               in_io;
		logic [IOL_W-1:0]   io_left;
		logic               was_running;
		logic [TICK_W-1:0]  ready_since;
	} slot_rec_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;
		logic mod_step;
		logic rd;
		logic io_proc;
		logic admit;
		logic age_proc;
		logic run_rd;
		logic run_proc;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic skip;
		logic sel_valid;
	} stat_t;

	typedef struct packed {
		logic               ran_valid;
		logic [PID_W-1:0]   ran_pid;
		logic [LVL_W-1:0]   ran_level;
		logic               finished;
		logic [TICK_W-1:0]  finish_tick;
		logic               sent_to_io;
		logic [STAT_W-1:0]  admit_status;
		logic [PID_W-1:0]   new_pid;
		logic [PROMO_W-1:0] promoted_count;
		logic [RET_W-1:0]   io_returned_count;
		logic               all_idle;
		logic [TICK_W-1:0]  tick_number;
	} result_t;

	// Divisible by three: fold base-4 digits, since 4 is 1 modulo 3
	function automatic logic mod3_zero(input logic [TICK_W-1:0] v);
		logic [4:0] s;
		logic [3:0] r;
		logic [2:0] t;
		s = '0;
		for (int k = 0; k < TICK_W / 2; k++) begin
			s = s + 5'(v[2*k +: 2]);
		end
		r = 4'(s[4:2]) + 4'(s[1:0]);
		t = 3'(r[3:2]) + 3'(r[1:0]);
		return (t == 3'd0) || (t == 3'd3);
	endfunction

endpackage
`default_nettype wire

[rtl/core/mlqs_if.sv]
// Request channel interfaces of the scheduler: tick requests in, tick reports out.
`timescale 1ns / 1ps
`default_nettype none
interface mlqs_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] new_burst;
	logic [1:0] new_level;
	logic       new_does_io;
	logic       memory_granted;

	modport source (output valid, new_burst, new_level, new_does_io, memory_granted,
		input ready);
	modport sink (input valid, new_burst, new_level, new_does_io, memory_granted,
		output ready);
endinterface

interface mlqs_out_if;
	logic        valid;
	logic        ready;
	logic        ran_valid;
	logic [7:0]  ran_pid;
	logic [1:0]  ran_level;
	logic        finished;
	logic [15:0] finish_tick;
	logic        sent_to_io;
	logic [1:0]  admit_status;
	logic [7:0]  new_pid;
	logic [5:0]  promoted_count;
	logic [4:0]  io_returned_count;
	logic        all_idle;
	logic [15:0] tick_number;

	modport source (output valid, ran_valid, ran_pid, ran_level, finished, finish_tick,
		sent_to_io, admit_status, new_pid, promoted_count, io_returned_count, all_idle,
		tick_number, input ready);
	modport sink (input valid, ran_valid, ran_pid, ran_level, finished, finish_tick,
		sent_to_io, admit_status, new_pid, promoted_count, io_returned_count, all_idle,
		tick_number, output ready);
endinterface
`default_nettype wire

[rtl/core/mlqs_ctl.sv]
// Controller of the scheduler: sequences the phases of one tick over the table.
`timescale 1ns / 1ps
`default_nettype none
module mlqs_ctl
	import mlqs_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
	localparam int CNT_W = (IDX_W > 4) ? IDX_W : 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             out_free,
	input  wire stat_t            stat,
	output cmd_t                  cmd,
	output logic [CNT_W-1:0]      idx
);

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_IO_RD, S_IO_PROC, S_ADMIT, S_CHK,
		S_AGE_RD, S_AGE_PROC, S_RUN_RD, S_RUN_PROC, S_DONE
	} state_t;

	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(TICK_W - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	assign idx      = cnt_q;
	assign in_ready = (state_q == S_IDLE);

	// Decode commands from the state
	always_comb begin
		cmd          = '0;
		cmd.start    = (state_q == S_IDLE) && in_valid;
		cmd.mod_step = (state_q == S_MOD);
		cmd.rd       = (state_q == S_IO_RD) || (state_q == S_AGE_RD) ||
			((state_q == S_RUN_RD) && stat.sel_valid);
		cmd.run_rd   = (state_q == S_RUN_RD);
		cmd.io_proc  = (state_q == S_IO_PROC);
		cmd.admit    = (state_q == S_ADMIT);
		cmd.age_proc = (state_q == S_AGE_PROC);
		cmd.run_proc = (state_q == S_RUN_PROC);
		cmd.finish   = (state_q == S_DONE) && out_free;
	end

	// Advance the phase sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) state_q <= S_MOD;
				end
				S_MOD: begin
					if (cnt_q == LAST_BIT) begin
						cnt_q   <= '0;
						state_q <= S_IO_RD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IO_RD: state_q <= S_IO_PROC;
				S_IO_PROC: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_ADMIT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_IO_RD;
					end
				end
				S_ADMIT: state_q <= S_CHK;
				S_CHK: state_q <= stat.skip ? S_DONE : S_AGE_RD;
				S_AGE_RD: state_q <= S_AGE_PROC;
				S_AGE_PROC: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_RUN_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_AGE_RD;
					end
				end
				S_RUN_RD: state_q <= stat.sel_valid ? S_RUN_PROC : S_DONE;
				S_RUN_PROC: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/mlqs_dp.sv]
// Datapath of the scheduler: process table memory, per-entry update units, pickers.
`timescale 1ns / 1ps
`default_nettype none
module mlqs_dp
	import mlqs_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int IO_TICKS    = IO_TICKS_DEF,
	localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
	localparam int CNT_W  = (IDX_W > 4) ? IDX_W : 4,
	localparam int UCNT_W = $clog2(TABLE_SLOTS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic [CNT_W-1:0]      idx,
	output stat_t                      stat,
	input  wire logic [BURST_W-1:0]    new_burst,
	input  wire logic [LVL_W-1:0]      new_level,
	input  wire logic                  new_does_io,
	input  wire logic                  memory_granted,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output result_t                    res
);

	// Configuration
	logic [INT_W-1:0] interval_q;
	logic [PID_W-1:0] limit_q;
	logic             sjf_q;
	logic [THR_W-1:0] thr_q;

	// Latched request
	logic [BURST_W-1:0] burst_q;
	logic [LVL_W-1:0]   level_q;
	logic               io_q;
	logic               mem_q;

	// Table and global state
	slot_rec_t               mem_q_arr [TABLE_SLOTS];
	slot_rec_t               rd_q;
	logic [TABLE_SLOTS-1:0]  used_q;
	logic [UCNT_W-1:0]       ucnt_q;
	logic [TICK_W-1:0]       tick_q;
	logic [NUM_W-1:0]        next_q;
	logic [INT_W-1:0]        rem_q;

	// Per-tick accumulation
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [RET_W-1:0]   ret_q;
	logic [PROMO_W-1:0] promo_q;
	logic [STAT_W-1:0]  status_q;
	logic [PID_W-1:0]   new_pid_q;
	logic               skip_q;
	logic               ran_q;
	logic [PID_W-1:0]   ran_pid_q;
	logic [LVL_W-1:0]   ran_lvl_q;
	logic               fin_q;
	logic [TICK_W-1:0]  fin_tick_q;
	logic               sent_q;

	// Best candidate per level: high, mid, low
	logic [2:0]         have_q;
	logic [IDX_W-1:0]   bidx_q [3];
	logic [TICK_W-1:0]  bage_q [3];
	logic [BURST_W-1:0] bkey_q [3];

	logic [IDX_W-1:0]   sidx;
	logic [IDX_W-1:0]   sel_idx;
	logic [LVL_W-1:0]   sel_lvl;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic               we;
	slot_rec_t          wdata;
	slot_rec_t          io_rec;
	slot_rec_t          age_rec;
	slot_rec_t          run_rec;
	slot_rec_t          new_rec;
	logic [IOL_W-1:0]   io_left_n;
	logic               ret_one;
	logic               rdy;
	logic               elig;
	logic [TICK_W-1:0]  wait_t;
	logic               up1;
	logic               up2;
	logic [1:0]         npromo;
	logic [6:0]         promo_sum;
	logic [TICK_W-1:0]  age_v;
	logic [BURST_W-1:0] key;
	logic [2:0]         upd;
	logic [BURST_W-1:0] rem_n;
	logic               run_fin;
	logic               run_io;
	logic               arrive_try;
	logic               admit_ok;
	logic [INT_W:0]     rem_ext;

	assign sidx = idx[IDX_W-1:0];

	// Load configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INT_W'(2);
			limit_q    <= PID_W'(16);
			sjf_q      <= 1'b0;
			thr_q      <= THR_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ARRIVAL: interval_q <= cfg_data[INT_W-1:0];
				CFG_LIMIT:   limit_q    <= cfg_data[PID_W-1:0];
				CFG_SJF:     sjf_q      <= cfg_data[0];
				CFG_AGING:   thr_q      <= cfg_data[THR_W-1:0];
				default:     ;
			endcase
		end
	end

	// Pick the highest nonempty level
	always_comb begin
		if (have_q[0]) begin
			sel_idx = bidx_q[0];
			sel_lvl = LVL_HIGH;
		end else if (have_q[1]) begin
			sel_idx = bidx_q[1];
			sel_lvl = LVL_MID;
		end else begin
			sel_idx = bidx_q[2];
			sel_lvl = LVL_LOW;
		end
	end

	assign stat.sel_valid = |have_q;
	assign stat.skip      = skip_q;

	// I/O countdown of one entry
	always_comb begin
		io_rec    = rd_q;
		ret_one   = 1'b0;
		io_left_n = rd_q.io_left - IOL_W'(rd_q.io_left != '0);
		if (used_q[sidx] && rd_q.in_io) begin
			io_rec.io_left = io_left_n;
			if (io_left_n == '0) begin
				io_rec.in_io       = 1'b0;
				io_rec.was_running = 1'b0;
				io_rec.ready_since = tick_q;
				ret_one            = 1'b1;
			end
		end
	end

	// Aging of one entry, low to mid then mid to high
	always_comb begin
		age_rec = rd_q;
		rdy     = used_q[sidx] && !rd_q.in_io;
		elig    = rdy && !rd_q.was_running;
		wait_t  = tick_q - rd_q.ready_since;
		up1     = elig && (rd_q.level == LVL_LOW) && (wait_t >= TICK_W'(thr_q));
		up2     = elig && (((rd_q.level == LVL_MID) && (wait_t >= TICK_W'(thr_q))) ||
			(up1 && (thr_q == '0)));
		if (up1 || up2) begin
			age_rec.ready_since = tick_q;
			age_rec.level       = up2 ? LVL_HIGH : LVL_MID;
		end
		npromo    = 2'(up1) + 2'(up2);
		promo_sum = 7'(promo_q) + 7'(npromo);
		age_v     = tick_q - rd_q.arrival;
		key       = sjf_q ? rd_q.remaining : rd_q.burst;
		for (int t = 0; t < 3; t++) begin
			if (t == 2) begin
				upd[t] = rdy && (age_rec.level == LVL_LOW) && (!have_q[t] ||
					(key < bkey_q[t]) || ((key == bkey_q[t]) && (age_v > bage_q[t])));
			end else begin
				upd[t] = rdy && (age_rec.level == LVL_W'(t + 1)) &&
					(!have_q[t] || (age_v > bage_q[t]));
			end
		end
	end

	// Run the selected entry for one tick
	always_comb begin
		run_rec             = rd_q;
		run_rec.was_running = 1'b1;
		rem_n               = rd_q.remaining - BURST_W'(rd_q.remaining != '0);
		run_rec.remaining   = rem_n;
		run_fin             = (rem_n == '0);
		run_io              = !run_fin && rd_q.io_cap && mod3_zero(tick_q - rd_q.arrival);
		if (run_io) begin
			run_rec.in_io   = 1'b1;
			run_rec.io_left = IOL_W'(IO_TICKS);
		end
	end

	// New entry from the latched request
	always_comb begin
		new_rec             = '0;
		new_rec.pid         = next_q[PID_W-1:0];
		new_rec.arrival     = tick_q;
		new_rec.burst       = burst_q;
		new_rec.remaining   = burst_q;
		new_rec.level       = (level_q == LVL_NONE) ? LVL_LOW : level_q;
		new_rec.io_cap      = io_q;
		new_rec.ready_since = tick_q;
	end

	assign arrive_try = (interval_q != '0) && (rem_q == '0) &&
		(next_q <= NUM_W'(limit_q));
	assign admit_ok   = arrive_try && free_found_q && mem_q;
	assign rem_ext    = {rem_q, tick_q[~idx[3:0]]};

	// Select the table port addresses and write data
	always_comb begin
		raddr = cmd.run_rd ? sel_idx : sidx;
		we    = 1'b0;
		waddr = sidx;
		wdata = rd_q;
		if (cmd.io_proc) begin
			we    = 1'b1;
			wdata = io_rec;
		end else if (cmd.age_proc) begin
			we    = 1'b1;
			wdata = age_rec;
		end else if (cmd.run_proc) begin
			we    = 1'b1;
			waddr = sel_idx;
			wdata = run_rec;
		end else if (cmd.admit && admit_ok) begin
			we    = 1'b1;
			waddr = free_idx_q;
			wdata = new_rec;
		end
	end

	// Table memory with registered read
	always_ff @(posedge clk) begin
		if (we) mem_q_arr[waddr] <= wdata;
		if (cmd.rd) rd_q <= mem_q_arr[raddr];
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			burst_q <= new_burst;
			level_q <= new_level;
			io_q    <= new_does_io;
			mem_q   <= memory_granted;
		end
	end

	// Tick state and per-tick accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			ucnt_q       <= '0;
			tick_q       <= '0;
			next_q       <= NUM_W'(1);
			rem_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			ret_q        <= '0;
			promo_q      <= '0;
			status_q     <= ADM_NONE;
			new_pid_q    <= '0;
			skip_q       <= 1'b0;
			ran_q        <= 1'b0;
			ran_pid_q    <= '0;
			ran_lvl_q    <= LVL_NONE;
			fin_q        <= 1'b0;
			fin_tick_q   <= '0;
			sent_q       <= 1'b0;
			have_q       <= '0;
			for (int t = 0; t < 3; t++) begin
				bidx_q[t] <= '0;
				bage_q[t] <= '0;
				bkey_q[t] <= '0;
			end
		end else begin
			if (cmd.start) begin
				rem_q        <= '0;
				free_found_q <= 1'b0;
				ret_q        <= '0;
				promo_q      <= '0;
				status_q     <= ADM_NONE;
				new_pid_q    <= '0;
				skip_q       <= 1'b0;
				ran_q        <= 1'b0;
				ran_pid_q    <= '0;
				ran_lvl_q    <= LVL_NONE;
				fin_q        <= 1'b0;
				fin_tick_q   <= '0;
				sent_q       <= 1'b0;
				have_q       <= '0;
			end
			// One restoring step of tick modulo interval
			if (cmd.mod_step) begin
				if (rem_ext >= {1'b0, interval_q}) begin
					rem_q <= INT_W'(rem_ext - {1'b0, interval_q});
				end else begin
					rem_q <= rem_ext[INT_W-1:0];
				end
			end
			if (cmd.io_proc) begin
				if (ret_one && (ret_q != '1)) ret_q <= ret_q + 1'b1;
				if (!used_q[sidx] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= sidx;
				end
			end
			if (cmd.admit && arrive_try) begin
				new_pid_q <= next_q[PID_W-1:0];
				next_q    <= next_q + 1'b1;
				if (!free_found_q) begin
					status_q <= ADM_FULL;
					skip_q   <= 1'b1;
				end else if (!mem_q) begin
					status_q <= ADM_NO_MEM;
					skip_q   <= 1'b1;
				end else begin
					status_q           <= ADM_OK;
					used_q[free_idx_q] <= 1'b1;
					ucnt_q             <= ucnt_q + 1'b1;
				end
			end
			if (cmd.age_proc) begin
				promo_q <= (promo_sum > 7'd63) ? '1 : promo_sum[PROMO_W-1:0];
				for (int t = 0; t < 3; t++) begin
					if (upd[t]) begin
						have_q[t] <= 1'b1;
						bidx_q[t] <= sidx;
						bage_q[t] <= age_v;
						bkey_q[t] <= key;
					end
				end
			end
			if (cmd.run_proc) begin
				ran_q     <= 1'b1;
				ran_pid_q <= rd_q.pid;
				ran_lvl_q <= sel_lvl;
				sent_q    <= run_io;
				if (run_fin) begin
					fin_q           <= 1'b1;
					fin_tick_q      <= tick_q + 1'b1;
					used_q[sel_idx] <= 1'b0;
					ucnt_q          <= ucnt_q - 1'b1;
				end
			end
			if (cmd.finish) tick_q <= tick_q + 1'b1;
		end
	end

	// Report of the tick
	always_comb begin
		res.ran_valid         = ran_q;
		res.ran_pid           = ran_pid_q;
		res.ran_level         = ran_lvl_q;
		res.finished          = fin_q;
		res.finish_tick       = fin_tick_q;
		res.sent_to_io        = sent_q;
		res.admit_status      = status_q;
		res.new_pid           = new_pid_q;
		res.promoted_count    = promo_q;
		res.io_returned_count = ret_q;
		res.all_idle          = (ucnt_q == '0);
		res.tick_number       = tick_q;
	end

endmodule
`default_nettype wire

[rtl/core/multilevel_queue_scheduler_aging.sv]
// Top level of the multilevel queue scheduler with aging.
//
// Each request on in_ch is one scheduler tick: it carries a possible arrival
// (burst, level, I/O flag, memory grant). Each tick gives exactly one report on
// out_ch: which process ran, admission outcome, aging and I/O return counts.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, as the block does not enforce it. A tick runs,
// from request to report, a bit-serial modulo of the tick count, then two
// sweeps over the table memory, each entry read and then written, then one
// read-modify-write of the chosen entry. A tick whose arrival is refused or
// finds the table full skips the second sweep and the run.
// One tick is processed at a time; in_ch.ready is high only while idle. The
// report sits in an output register, so the next request is taken while it
// waits; a stalled receiver holds the finished tick until the register frees.
// Reset clears the table, the tick count (to 0), the process number (to 1)
// and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_queue_scheduler_aging
	import mlqs_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int IO_TICKS    = IO_TICKS_DEF,
	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
	localparam int CNT_W = (IDX_W > 4) ? IDX_W : 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mlqs_in_if.sink                    in_ch,
	mlqs_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t             cmd;
	stat_t            stat;
	logic [CNT_W-1:0] idx;
	logic             out_free;
	logic             out_valid_q;
	result_t          res;
	result_t          res_q;

	assign out_free = !out_valid_q || out_ch.ready;

	mlqs_ctl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_free(out_free),
		.stat    (stat),
		.cmd     (cmd),
		.idx     (idx)
	);

	mlqs_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.IO_TICKS   (IO_TICKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.idx           (idx),
		.stat          (stat),
		.new_burst     (in_ch.new_burst),
		.new_level     (in_ch.new_level),
		.new_does_io   (in_ch.new_does_io),
		.memory_granted(in_ch.memory_granted),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.res           (res)
	);

	// Hold the report until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) res_q <= res;
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.ran_valid         = res_q.ran_valid;
	assign out_ch.ran_pid           = res_q.ran_pid;
	assign out_ch.ran_level         = res_q.ran_level;
	assign out_ch.finished          = res_q.finished;
	assign out_ch.finish_tick       = res_q.finish_tick;
	assign out_ch.sent_to_io        = res_q.sent_to_io;
	assign out_ch.admit_status      = res_q.admit_status;
	assign out_ch.new_pid           = res_q.new_pid;
	assign out_ch.promoted_count    = res_q.promoted_count;
	assign out_ch.io_returned_count = res_q.io_returned_count;
	assign out_ch.all_idle          = res_q.all_idle;
	assign out_ch.tick_number       = res_q.tick_number;

	// One tick in flight: a taken request closes the input
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request taken while a tick is in progress");

	// A finished process neither stays nor leaves for I/O, and it ran
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.finished |-> out_ch.ran_valid && !out_ch.sent_to_io)
		else $error("finish reported without a run or together with I/O");

	// No arrival attempt gives no number
	a_no_pid: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.admit_status == ADM_NONE) |-> (out_ch.new_pid == '0))
		else $error("process number given without an arrival");

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench of the multilevel queue scheduler with aging.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import mlqs_pkg::*;

	localparam int SLOTS     = 16;
	localparam int IO_WAIT   = 3;
	localparam int IO_EVERY  = 3;
	localparam int SETTLE    = 120;
	localparam int MAX_CYCLES = 600000;
	localparam logic [16:0] RAN_MARK = 17'h1FFFF;

	// Expected tick reports, oldest first
	class tick_scoreboard;
		result_t expected_reports[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_tick(result_t r);
			expected_reports = {expected_reports, r};
		endfunction

		function void check_report(result_t act);
			result_t e;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected report %p", act);
				return;
			end
			e = expected_reports.pop_front();
			if (act.ran_valid !== e.ran_valid || act.ran_pid !== e.ran_pid ||
				act.ran_level !== e.ran_level || act.finished !== e.finished ||
				act.finish_tick !== e.finish_tick || act.sent_to_io !== e.sent_to_io ||
				act.admit_status !== e.admit_status || act.new_pid !== e.new_pid ||
				act.promoted_count !== e.promoted_count ||
				act.io_returned_count !== e.io_returned_count ||
				act.all_idle !== e.all_idle || act.tick_number !== e.tick_number) begin
				errors++;
				if (errors <= 10)
					$display("tick %0d mismatch\n  exp %p\n  got %p", e.tick_number, e, act);
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mlqs_in_if in_ch();
	mlqs_out_if out_ch();

	multilevel_queue_scheduler_aging DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tick_scoreboard sb = new();

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Scheduler shadow state
	logic [3:0] sh_interval;
	logic [7:0] sh_limit;
	logic       sh_by_remaining;
	logic [7:0] sh_threshold;
	logic        sh_used [SLOTS];
	logic [7:0]  sh_pid [SLOTS];
	logic [15:0] sh_arrival [SLOTS];
	logic [3:0]  sh_burst [SLOTS];
	logic [3:0]  sh_remaining [SLOTS];
	logic [1:0]  sh_level [SLOTS];
	logic        sh_io_cap [SLOTS];
	logic        sh_in_io [SLOTS];
	logic [1:0]  sh_io_left [SLOTS];
	logic        sh_ran [SLOTS];
	logic [16:0] sh_since [SLOTS];
	logic [15:0] sh_tick;
	logic [8:0]  sh_next_pid;

	function automatic logic waiting_at(int i, logic [1:0] lvl);
		return sh_used[i] && !sh_in_io[i] && sh_level[i] == lvl;
	endfunction

	function automatic logic [15:0] age_since_arrival(int i);
		return 16'(sh_tick - sh_arrival[i]);
	endfunction

	// Promote entries of one level that waited past the threshold
	function automatic int promote_level(logic [1:0] from_lvl, logic [1:0] to_lvl);
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (waiting_at(i, from_lvl) && sh_since[i] != RAN_MARK &&
				16'(sh_tick - sh_since[i][15:0]) >= sh_threshold) begin
				sh_level[i] = to_lvl;
				sh_since[i] = {1'b0, sh_tick};
				n++;
			end
		end
		return n;
	endfunction

	// Oldest arrival on high and mid, shortest job on low
	function automatic int choose_slot(logic [1:0] lvl);
		int best;
		logic [3:0] ki, kb;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!waiting_at(i, lvl))
				continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			if (lvl == LVL_LOW) begin
				ki = sh_by_remaining ? sh_remaining[i] : sh_burst[i];
				kb = sh_by_remaining ? sh_remaining[best] : sh_burst[best];
				if (ki < kb || (ki == kb && age_since_arrival(i) > age_since_arrival(best)))
					best = i;
			end else if (age_since_arrival(i) > age_since_arrival(best)) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic result_t schedule_tick(logic [3:0] burst, logic [1:0] lvl_in,
		logic does_io, logic mem_ok);
		result_t r;
		int free_slot, sel, promos, back;
		logic skip;
		r = '0;
		skip = 1'b0;
		back = 0;
		promos = 0;
		// Count down I/O waits
		for (int i = 0; i < SLOTS; i++) begin
			if (sh_used[i] && sh_in_io[i]) begin
				if (sh_io_left[i] > 0)
					sh_io_left[i]--;
				if (sh_io_left[i] == 0) begin
					sh_in_io[i] = 1'b0;
					sh_ran[i] = 1'b0;
					sh_since[i] = {1'b0, sh_tick};
					back++;
				end
			end
		end
		// Admit an arrival
		if (sh_interval != 0 && (sh_tick % sh_interval) == 0 && sh_next_pid <= sh_limit) begin
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!sh_used[i])
					free_slot = i;
			r.new_pid = sh_next_pid[7:0];
			sh_next_pid++;
			if (free_slot < 0) begin
				r.admit_status = ADM_FULL;
				skip = 1'b1;
			end else if (!mem_ok) begin
				r.admit_status = ADM_NO_MEM;
				skip = 1'b1;
			end else begin
				r.admit_status = ADM_OK;
				sh_used[free_slot] = 1'b1;
				sh_pid[free_slot] = r.new_pid;
				sh_arrival[free_slot] = sh_tick;
				sh_burst[free_slot] = burst;
				sh_remaining[free_slot] = burst;
				sh_level[free_slot] = (lvl_in == LVL_NONE) ? LVL_LOW : lvl_in;
				sh_io_cap[free_slot] = does_io;
				sh_in_io[free_slot] = 1'b0;
				sh_io_left[free_slot] = '0;
				sh_ran[free_slot] = 1'b0;
				sh_since[free_slot] = {1'b0, sh_tick};
			end
		end
		// Age, select, run
		if (!skip) begin
			promos = promote_level(LVL_LOW, LVL_MID);
			promos += promote_level(LVL_MID, LVL_HIGH);
			sel = choose_slot(LVL_HIGH);
			r.ran_level = LVL_HIGH;
			if (sel < 0) begin
				sel = choose_slot(LVL_MID);
				r.ran_level = LVL_MID;
			end
			if (sel < 0) begin
				sel = choose_slot(LVL_LOW);
				r.ran_level = LVL_LOW;
			end
			if (sel < 0) begin
				r.ran_level = LVL_NONE;
			end else begin
				r.ran_valid = 1'b1;
				r.ran_pid = sh_pid[sel];
				if (!sh_ran[sel]) begin
					sh_ran[sel] = 1'b1;
					sh_since[sel] = RAN_MARK;
				end
				if (sh_remaining[sel] > 0)
					sh_remaining[sel]--;
				if (sh_remaining[sel] == 0) begin
					r.finished = 1'b1;
					r.finish_tick = 16'(sh_tick + 16'd1);
					sh_used[sel] = 1'b0;
				end else if (sh_io_cap[sel] && (age_since_arrival(sel) % IO_EVERY) == 0) begin
					r.sent_to_io = 1'b1;
					sh_in_io[sel] = 1'b1;
					sh_io_left[sel] = 2'(IO_WAIT);
				end
			end
		end
		r.all_idle = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			if (sh_used[i])
				r.all_idle = 1'b0;
		r.promoted_count = (promos > 63) ? 6'd63 : 6'(promos);
		r.io_returned_count = (back > 31) ? 5'd31 : 5'(back);
		r.tick_number = sh_tick;
		sh_tick++;
		return r;
	endfunction

	// Receiver: stall pattern that steps through four modes in turn
	int cycle_count;
	always @(posedge clk) begin
		case ((cycle_count / 300) % 4)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 3) != 0);
			2: out_ch.ready <= ((cycle_count % 7) < 2);
			default: out_ch.ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	// Sample the report channel mid-cycle, check at the edge that takes it
	logic    report_taken;
	result_t report_seen;
	always @(negedge clk) begin
		report_taken <= out_ch.valid && out_ch.ready && arst_n;
		report_seen <= {out_ch.ran_valid, out_ch.ran_pid, out_ch.ran_level, out_ch.finished,
			out_ch.finish_tick, out_ch.sent_to_io, out_ch.admit_status, out_ch.new_pid,
			out_ch.promoted_count, out_ch.io_returned_count, out_ch.all_idle,
			out_ch.tick_number};
	end
	always @(posedge clk) begin
		if (report_taken)
			sb.check_report(report_seen);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Hold one tick request until it is taken; call at a rising edge
	task automatic send_tick(logic [3:0] burst, logic [1:0] lvl, logic does_io, logic mem_ok);
		logic took;
		in_ch.valid <= 1'b1;
		in_ch.new_burst <= burst;
		in_ch.new_level <= lvl;
		in_ch.new_does_io <= does_io;
		in_ch.memory_granted <= mem_ok;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		sb.note_tick(schedule_tick(burst, lvl, does_io, mem_ok));
	endtask

	// Send random ticks in bursts with gaps
	task automatic send_random_ticks(int count, int max_gap);
		int left, run, gap;
		left = count;
		while (left > 0) begin
			run = $urandom_range(1, 10);
			for (int k = 0; k < run && left > 0; k++) begin
				send_tick(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0));
				left--;
			end
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for all reports, then write every register
	task automatic write_settings(logic [3:0] interval, logic [7:0] limit, logic by_rem,
		logic [7:0] thr);
		logic [7:0] vals [4];
		logic [CFG_IDX_W-1:0] regs [4];
		vals = '{8'(interval), limit, 8'(by_rem), thr};
		regs = '{CFG_ARRIVAL, CFG_LIMIT, CFG_SJF, CFG_AGING};
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sh_interval = interval;
		sh_limit = limit;
		sh_by_remaining = by_rem;
		sh_threshold = thr;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		report_taken = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ARRIVAL;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.new_burst = '0;
		in_ch.new_level = LVL_NONE;
		in_ch.new_does_io = 1'b0;
		in_ch.memory_granted = 1'b0;
		out_ch.ready = 1'b0;
		sh_interval = 4'd2;
		sh_limit = 8'd16;
		sh_by_remaining = 1'b0;
		sh_threshold = 8'd10;
		for (int i = 0; i < SLOTS; i++) begin
			sh_used[i] = 1'b0;
			sh_ran[i] = 1'b0;
			sh_in_io[i] = 1'b0;
		end
		sh_tick = '0;
		sh_next_pid = 9'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: interval 1 so every tick may admit
		write_settings(4'd1, 8'd255, 1'b0, 8'd3);
		send_tick(4'd0, LVL_LOW, 1'b0, 1'b1);
		send_tick(4'd15, LVL_NONE, 1'b1, 1'b1);
		send_tick(4'd1, LVL_HIGH, 1'b1, 1'b0);
		send_tick(4'd15, LVL_HIGH, 1'b1, 1'b1);
		send_tick(4'd7, LVL_MID, 1'b1, 1'b1);
		send_tick(4'd3, LVL_LOW, 1'b0, 1'b1);
		send_tick(4'd3, LVL_LOW, 1'b1, 1'b1);
		send_tick(4'd10, LVL_MID, 1'b0, 1'b0);
		for (int k = 0; k < 12; k++)
			send_tick(4'($urandom_range(8, 15)), LVL_LOW, 1'b1, 1'b1);
		in_ch.valid <= 1'b0;
		@(posedge clk);

		// Table full and low level by remaining time
		send_random_ticks(60, 0);
		write_settings(4'd3, 8'd200, 1'b1, 8'd0);
		send_random_ticks(100, 4);
		// Widest interval, slowest aging
		write_settings(4'd15, 8'd255, 1'b0, 8'd255);
		send_random_ticks(60, 2);
		// No arrivals at all
		write_settings(4'd0, 8'd255, 1'b1, 8'd1);
		send_random_ticks(40, 3);
		// Busy table, moderate aging
		write_settings(4'd2, 8'd255, 1'b1, 8'd6);
		send_random_ticks(180, 5);
		write_settings(4'd1, 8'd255, 1'b0, 8'd20);
		send_random_ticks(120, 1);
		// Process numbers used up
		write_settings(4'd1, 8'd0, 1'b0, 8'd2);
		send_random_ticks(40, 2);

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_if.sv
rtl/core/mlqs_ctl.sv
rtl/core/mlqs_dp.sv
rtl/core/multilevel_queue_scheduler_aging.sv
verif/testbench.sv
